// File: rtl/core/ptlm_pkg.sv
package ptlm_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = 128;
   localparam int HALF_W = 64;
   localparam int V4_W = 32;
   localparam int LEN_W = 8;
   localparam int OUT_IDX_W = 6;

   localparam logic [LEN_W-1:0] V4_LEN_MAX = LEN_W'(V4_W);
   localparam logic [LEN_W-1:0] V6_LEN_MAX = LEN_W'(ADDR_W);

   localparam logic [1:0] FAM_NONE = 2'd0;
   localparam logic [1:0] FAM_V4 = 2'd1;
   localparam logic [1:0] FAM_V6 = 2'd2;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      STATUS_NONE = 3'd0,
      STATUS_EXACT = 3'd1,
      STATUS_CONTAINED = 3'd2,
      STATUS_ADDED = 3'd3,
      STATUS_PRESENT = 3'd4,
      STATUS_FULL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic action;
      logic [1:0] family;
      logic [HALF_W-1:0] addr_high;
      logic [HALF_W-1:0] addr_low;
      logic [LEN_W-1:0] prefix_len;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [LEN_W-1:0] matched_len;
      logic [OUT_IDX_W-1:0] matched_index;
      logic table_empty;
   } rsp_type;

   typedef struct packed {
      logic is_v6;
      logic [LEN_W-1:0] length;
      logic [ADDR_W-1:0] addr;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic [IDX_W-1:0] idx;
   } match_ctrl_type;

   typedef struct packed {
      logic hit;
      logic [IDX_W-1:0] hit_idx;
      logic [LEN_W-1:0] best_len;
      logic [IDX_W-1:0] best_idx;
   } match_result_type;

endpackage

// File: rtl/core/ptlm_entry_ram.sv
module ptlm_entry_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ptlm_pkg::IDX_W-1:0]  wr_addr,
   input  ptlm_pkg::entry_type         wr_data,
   input  logic                        rd_en,
   input  logic [ptlm_pkg::IDX_W-1:0]  rd_addr,
   output ptlm_pkg::entry_type         rd_data
);

   ptlm_pkg::entry_type mem_ff [ptlm_pkg::TABLE_ENTRIES];
   ptlm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ptlm_match.sv
module ptlm_match (
   input  logic                           clock,
   input  logic                           reset,
   input  ptlm_pkg::match_ctrl_type       ctrl,
   input  ptlm_pkg::entry_type            query,
   input  ptlm_pkg::entry_type            entry,
   output ptlm_pkg::match_result_type     result
);

   localparam logic [ptlm_pkg::ADDR_W-1:0] ALL_ONES = '1;

   logic                            hit_ff, hit_in;
   logic [ptlm_pkg::IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [ptlm_pkg::LEN_W-1:0]      best_len_ff, best_len_in;
   logic [ptlm_pkg::IDX_W-1:0]      best_idx_ff, best_idx_in;

   logic                            fam_eq;
   logic                            exact;
   logic                            contain;
   logic [ptlm_pkg::ADDR_W-1:0]     top_mask;

   always_comb begin
      fam_eq = (entry.is_v6 == query.is_v6);
      exact = fam_eq && (entry.length == query.length) && (entry.addr == query.addr);
      // keep only the entry's top length bits
      top_mask = ~(ALL_ONES >> entry.length);
      contain = fam_eq && (entry.length > best_len_ff) && (entry.length < query.length) &&
                (((entry.addr ^ query.addr) & top_mask) == '0);
   end

   always_comb begin
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      best_len_in = best_len_ff;
      best_idx_in = best_idx_ff;
      if (ctrl.clear) begin
         hit_in = 1'b0;
         best_len_in = '0;
      end else if (ctrl.valid) begin
         if (exact && !hit_ff) begin
            hit_in = 1'b1;
            hit_idx_in = ctrl.idx;
         end
         // strictly longer only: first inserted wins a tie
         if (contain) begin
            best_len_in = entry.length;
            best_idx_in = ctrl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         best_len_ff <= '0;
      end else begin
         hit_ff <= hit_in;
         best_len_ff <= best_len_in;
      end
      hit_idx_ff <= hit_idx_in;
      best_idx_ff <= best_idx_in;
   end

   assign result = '{hit: hit_ff, hit_idx: hit_idx_ff,
                     best_len: best_len_ff, best_idx: best_idx_ff};

endmodule

// File: rtl/core/prefix_table_longest_match_unit.sv
// Channel    Direction  Ports                          Transfer when
// request    in         req_valid req_stall req_data   req_valid && !req_stall
// response   out        rsp_valid rsp_stall rsp_data   rsp_valid && !rsp_stall
//
// One item at a time: the entry memory is scanned one slot per cycle over the N entries
// held, then a drain step and a finish step give the result; an empty table or a family
// other than IPv4 or IPv6 goes straight to the finish step. The one memory read port sets this.
// Synchronous reset empties the table; no clearing pass is needed.
// A result waits in the output register under rsp_stall; the next request is
// taken meanwhile, and its finish step holds until the output register frees.
module prefix_table_longest_match_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ptlm_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ptlm_pkg::rsp_type    rsp_data
);

   ptlm_pkg::state_type            state_ff, state_in;
   logic [ptlm_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [ptlm_pkg::IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                           cmp_valid_ff, cmp_valid_in;
   logic [ptlm_pkg::IDX_W-1:0]     cmp_idx_ff;
   ptlm_pkg::entry_type            query_ff, query_in;
   logic                           action_ff;
   logic                           query_ok_ff, query_ok_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ptlm_pkg::rsp_type              rsp_data_ff, rsp_in;

   logic                           req_xfer;
   logic                           rsp_free;
   logic                           scan_last;
   logic                           table_full;
   logic                           rd_en;
   logic                           wr_en;
   logic                           rsp_load;
   ptlm_pkg::entry_type            rd_data;
   ptlm_pkg::match_ctrl_type       match_ctrl;
   ptlm_pkg::match_result_type     match_res;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (ptlm_pkg::CNT_W'(scan_idx_ff) == count_ff - ptlm_pkg::CNT_W'(1));
   assign table_full = (count_ff == ptlm_pkg::CNT_W'(ptlm_pkg::TABLE_ENTRIES));

   // decode and saturate the query at transfer
   always_comb begin
      query_in = query_ff;
      query_ok_in = 1'b0;
      unique case (req_data.family)
         ptlm_pkg::FAM_V4: begin
            query_ok_in = 1'b1;
            query_in.is_v6 = 1'b0;
            query_in.addr = {req_data.addr_low[ptlm_pkg::V4_W-1:0],
                             {(ptlm_pkg::ADDR_W - ptlm_pkg::V4_W){1'b0}}};
            query_in.length = (req_data.prefix_len > ptlm_pkg::V4_LEN_MAX) ?
                              ptlm_pkg::V4_LEN_MAX : req_data.prefix_len;
         end
         ptlm_pkg::FAM_V6: begin
            query_ok_in = 1'b1;
            query_in.is_v6 = 1'b1;
            query_in.addr = {req_data.addr_high, req_data.addr_low};
            query_in.length = (req_data.prefix_len > ptlm_pkg::V6_LEN_MAX) ?
                              ptlm_pkg::V6_LEN_MAX : req_data.prefix_len;
         end
         default: begin
            query_ok_in = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptlm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (query_ok_in && (count_ff != '0)) begin
                  state_in = ptlm_pkg::ST_SCAN;
               end else begin
                  state_in = ptlm_pkg::ST_FINISH;
               end
            end
         end
         ptlm_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = ptlm_pkg::ST_DRAIN;
            end
         end
         ptlm_pkg::ST_DRAIN: begin
            state_in = ptlm_pkg::ST_FINISH;
         end
         ptlm_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = ptlm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptlm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en = 1'b0;
      wr_en = 1'b0;
      rsp_load = 1'b0;
      scan_idx_in = scan_idx_ff;
      cmp_valid_in = 1'b0;
      count_in = count_ff;
      rsp_in = '{status: ptlm_pkg::STATUS_NONE, matched_len: '0,
                 matched_index: '0, table_empty: (count_ff == '0)};
      unique case (state_ff)
         ptlm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            scan_idx_in = '0;
         end
         ptlm_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            cmp_valid_in = 1'b1;
            scan_idx_in = scan_idx_ff + ptlm_pkg::IDX_W'(1);
         end
         ptlm_pkg::ST_DRAIN: begin
         end
         ptlm_pkg::ST_FINISH: begin
            rsp_load = rsp_free;
            if (query_ok_ff) begin
               if (match_res.hit) begin
                  rsp_in.status = (action_ff == ptlm_pkg::ACT_ADD) ?
                                  ptlm_pkg::STATUS_PRESENT : ptlm_pkg::STATUS_EXACT;
                  rsp_in.matched_len = query_ff.length;
                  rsp_in.matched_index = ptlm_pkg::OUT_IDX_W'(match_res.hit_idx);
               end else if (action_ff == ptlm_pkg::ACT_ADD) begin
                  if (table_full) begin
                     rsp_in.status = ptlm_pkg::STATUS_FULL;
                  end else begin
                     rsp_in.status = ptlm_pkg::STATUS_ADDED;
                     rsp_in.matched_len = query_ff.length;
                     rsp_in.matched_index = ptlm_pkg::OUT_IDX_W'(count_ff);
                     rsp_in.table_empty = 1'b0;
                     wr_en = rsp_free;
                     if (rsp_free) begin
                        count_in = count_ff + ptlm_pkg::CNT_W'(1);
                     end
                  end
               end else if (match_res.best_len != '0) begin
                  rsp_in.status = ptlm_pkg::STATUS_CONTAINED;
                  rsp_in.matched_len = match_res.best_len;
                  rsp_in.matched_index = ptlm_pkg::OUT_IDX_W'(match_res.best_idx);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptlm_pkg::ST_IDLE;
         count_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff <= scan_idx_ff;
      if (req_xfer) begin
         query_ff <= query_in;
         query_ok_ff <= query_ok_in;
         action_ff <= req_data.action;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign match_ctrl = '{clear: req_xfer, valid: cmp_valid_ff, idx: cmp_idx_ff};

   // writes happen only after the scan ends, so read and write never overlap
   ptlm_entry_ram u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ptlm_pkg::IDX_W-1:0]),
      .wr_data (query_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   ptlm_match u_match (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (match_ctrl),
      .query  (query_ff),
      .entry  (rd_data),
      .result (match_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: rtl/core/ptlm_checker.sv
module ptlm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input ptlm_pkg::req_type    req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ptlm_pkg::rsp_type    rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   a_no_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ptlm_pkg::STATUS_NONE ||
                    rsp_data.status == ptlm_pkg::STATUS_FULL) |->
      rsp_data.matched_len == '0 && rsp_data.matched_index == '0)
      else $error("nonzero length or index without a match");

   a_added_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ptlm_pkg::STATUS_ADDED ||
                    rsp_data.status == ptlm_pkg::STATUS_PRESENT ||
                    rsp_data.status == ptlm_pkg::STATUS_FULL) |-> !rsp_data.table_empty)
      else $error("table reported empty after an add");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind prefix_table_longest_match_unit ptlm_checker u_checker (.*);

// File: sim/prefix_table_longest_match_unit_tb.sv
`timescale 1ns / 100ps

import ptlm_pkg::*;

// Keeps its own copy of the prefix table and the queue of responses still owed by the block.
class prefix_match_scoreboard;
   entry_type entries[$];
   rsp_type   awaited_rsp[$];
   int        errors = 0;

   // Apply one request to the table copy and return the response it must produce.
   function rsp_type table_outcome(req_type r);
      rsp_type          res;
      entry_type        key;
      logic [LEN_W-1:0] best;
      int               hit;
      res = '0;
      res.status = STATUS_NONE;
      if (r.family == FAM_V4 || r.family == FAM_V6) begin
         key.is_v6 = (r.family == FAM_V6);
         if (key.is_v6) begin
            key.addr = {r.addr_high, r.addr_low};
            key.length = (r.prefix_len > V6_LEN_MAX) ? V6_LEN_MAX : r.prefix_len;
         end else begin
            key.addr = {r.addr_low[V4_W-1:0], {(ADDR_W-V4_W){1'b0}}};
            key.length = (r.prefix_len > V4_LEN_MAX) ? V4_LEN_MAX : r.prefix_len;
         end
         hit = -1;
         foreach (entries[i])
            if (hit < 0 && entries[i] == key) hit = i;
         if (r.action == ACT_ADD) begin
            if (hit >= 0) begin
               res.status = STATUS_PRESENT;
               res.matched_len = key.length;
               res.matched_index = OUT_IDX_W'(hit);
            end else if (entries.size() >= TABLE_ENTRIES) begin
               res.status = STATUS_FULL;
            end else begin
               res.status = STATUS_ADDED;
               res.matched_len = key.length;
               res.matched_index = OUT_IDX_W'(entries.size());
               entries.push_back(key);
            end
         end else if (hit >= 0) begin
            res.status = STATUS_EXACT;
            res.matched_len = key.length;
            res.matched_index = OUT_IDX_W'(hit);
         end else begin
            // strict > keeps the first inserted among equal lengths and skips length zero
            best = '0;
            foreach (entries[i])
               if (entries[i].is_v6 == key.is_v6 && entries[i].length > best &&
                   entries[i].length < key.length &&
                   ((entries[i].addr ^ key.addr) >> (ADDR_W - entries[i].length)) == '0) begin
                  best = entries[i].length;
                  res.matched_index = OUT_IDX_W'(i);
               end
            if (best != '0) begin
               res.status = STATUS_CONTAINED;
               res.matched_len = best;
            end else begin
               res.matched_index = '0;
            end
         end
      end
      res.table_empty = (entries.size() == 0);
      return res;
   endfunction

   function void note_request(req_type r);
      awaited_rsp.push_back(table_outcome(r));
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (awaited_rsp.size() == 0) begin
         errors++;
         $display("%0t: response with none expected, expected nothing, actual %p", $time, got);
         return;
      end
      want = awaited_rsp.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("matched_len", want.matched_len, got.matched_len);
      compare_field("matched_index", 8'(want.matched_index), 8'(got.matched_index));
      compare_field("table_empty", 8'(want.table_empty), 8'(got.table_empty));
   endfunction

   function int pending();
      return awaited_rsp.size();
   endfunction
endclass

module prefix_table_longest_match_unit_tb;

   localparam logic [1:0] FAM_RESERVED = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 125;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   prefix_match_scoreboard board = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int idle_cycles;

   int phase_send_pct[4] = '{0, 69, 0, 10};
   int phase_recv_pct[4] = '{0, 0, 69, 10};

   prefix_table_longest_match_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] rand128();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [V4_W-1:0] v4_addr_dummy();
      return $urandom;
   endfunction

   function automatic logic [ADDR_W-1:0] v4(logic [V4_W-1:0] a);
      return {a, {(ADDR_W-V4_W){1'b0}}};
   endfunction

   // Build a request from a left-aligned 128-bit address; ignored IPv4 bits get junk.
   function automatic req_type make_req(logic act, logic [1:0] fam, logic [ADDR_W-1:0] a,
                                        logic [LEN_W-1:0] len);
      req_type r;
      r.action = act;
      r.family = fam;
      r.prefix_len = len;
      if (fam == FAM_V6) begin
         {r.addr_high, r.addr_low} = a;
      end else begin
         r.addr_high = {$urandom, $urandom};
         r.addr_low = {v4_addr_dummy(), a[ADDR_W-1:ADDR_W-V4_W]};
      end
      return r;
   endfunction

   // Keep the top keep bits of a, randomize the host bits below them.
   function automatic logic [ADDR_W-1:0] keep_top(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] keep);
      logic [ADDR_W-1:0] mask;
      mask = {ADDR_W{1'b1}} << (ADDR_W - keep);
      return (a & mask) | (rand128() & ~mask);
   endfunction

   function automatic logic [LEN_W-1:0] random_len(logic [1:0] fam);
      if ($urandom_range(15) == 0) return LEN_W'($urandom_range(255));
      return LEN_W'($urandom_range((fam == FAM_V6) ? V6_LEN_MAX : V4_LEN_MAX));
   endfunction

   // Mostly adds and lookups built around prefixes already held, plus some noise.
   function automatic req_type next_random_req();
      req_type          r;
      entry_type        pick;
      logic [1:0]       fam;
      logic             act;
      logic [LEN_W-1:0] len_max;
      logic [LEN_W-1:0] len;
      int               roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         r.action = 1'($urandom_range(1));
         r.family = 2'($urandom_range(3));
         r.addr_high = {$urandom, $urandom};
         r.addr_low = {$urandom, $urandom};
         r.prefix_len = LEN_W'($urandom_range(255));
         return r;
      end
      act = (roll < 38) ? ACT_ADD : ACT_LOOKUP;
      if (board.entries.size() == 0 || $urandom_range(99) < 25) begin
         fam = $urandom_range(1) ? FAM_V6 : FAM_V4;
         return make_req(act, fam, rand128(), random_len(fam));
      end
      pick = board.entries[$urandom_range(board.entries.size() - 1)];
      fam = pick.is_v6 ? FAM_V6 : FAM_V4;
      len_max = pick.is_v6 ? V6_LEN_MAX : V4_LEN_MAX;
      if ($urandom_range(3) == 0) begin
         len = pick.length;
         if (pick.length == len_max && $urandom_range(1))
            len = LEN_W'($urandom_range(255, len_max));
         return make_req(act, fam, pick.addr, len);
      end
      len = ($urandom_range(9) == 0) ? LEN_W'(255) : LEN_W'($urandom_range(len_max, pick.length));
      return make_req(act, fam, keep_top(pick.addr, pick.length), len);
   endfunction

   task automatic send_req(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   // Stop offering and wait for every outstanding response.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Response side: random stall, or a long hold when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // End the run after too long without any transfer on either channel.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'h0A010203), 8'd32));
      send_req(make_req(ACT_ADD, FAM_NONE, rand128(), 8'd16));
      send_req(make_req(ACT_ADD, FAM_RESERVED, rand128(), 8'd255));
      send_req(make_req(ACT_ADD, FAM_V4, v4(32'h0A000000), 8'd8));
      send_req(make_req(ACT_ADD, FAM_V4, v4(32'h0A000000), 8'd8));
      // length above 32 saturates
      send_req(make_req(ACT_ADD, FAM_V4, v4(32'h0A010203), 8'd200));
      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'h0A010203), 8'd32));
      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'h0A090909), 8'd32));
      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'h0A090909), 8'd8));
      send_req(make_req(ACT_ADD, FAM_V4, v4(32'h00000000), 8'd0));
      // zero-length entry must not contain anything
      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'hC0A80001), 8'd32));
      send_req(make_req(ACT_LOOKUP, FAM_V4, v4(32'h00000000), 8'd0));
      send_req(make_req(ACT_ADD, FAM_V6, {ADDR_W{1'b1}}, 8'd255));
      send_req(make_req(ACT_ADD, FAM_V6, {64'hFFFF_0000_1234_5678, 64'h1}, 8'd64));
      // same length and top bits, different host bits: first inserted wins
      send_req(make_req(ACT_ADD, FAM_V6, {64'hFFFF_0000_1234_5678, 64'h2}, 8'd64));
      send_req(make_req(ACT_ADD, FAM_V6, {64'hFFFF_0000_1234_5678, 64'h0}, 8'd48));
      send_req(make_req(ACT_LOOKUP, FAM_V6, {64'hFFFF_0000_1234_5678, 64'hDEAD}, 8'd128));
      send_req(make_req(ACT_LOOKUP, FAM_V6, {64'hFFFF_0000_1234_5678, 64'hDEAD}, 8'd64));
      send_req(make_req(ACT_LOOKUP, FAM_V6, {ADDR_W{1'b1}}, 8'd128));
      send_req(make_req(ACT_LOOKUP, FAM_V6, '0, 8'd128));
      send_req(make_req(ACT_LOOKUP, FAM_V4, {ADDR_W{1'b1}}, 8'd255));
      send_req(make_req(ACT_LOOKUP, FAM_NONE, rand128(), 8'd8));
      send_req(make_req(ACT_LOOKUP, FAM_RESERVED, rand128(), 8'd128));
      send_req(make_req(ACT_ADD, FAM_V6, '0, 8'd0));
      send_req(make_req(ACT_LOOKUP, FAM_V6, '0, 8'd0));
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_send_pct[ph];
         recv_stall_pct = phase_recv_pct[ph];
         // hold the response side while requests keep coming, so the block backs up
         if (ph == 0) hold_left = HOLD_CYCLES;
         for (int n = 0; n < PHASE_ITEMS; n++) send_req(next_random_req());
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ptlm_pkg.sv
rtl/core/ptlm_entry_ram.sv
rtl/core/ptlm_match.sv
rtl/core/prefix_table_longest_match_unit.sv
rtl/core/ptlm_checker.sv
sim/prefix_table_longest_match_unit_tb.sv
